// ===== rtl/button_gesture_classifier_assert.svh =====
// Assertion macros used by the port checker file.
// Each use stands on a line of its own.
`ifndef BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define BGC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgc assertion failed");

// Next-cycle implication, masked during reset.
`define BGC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgc assertion failed");

`endif

// ===== rtl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// Types, constants and helpers of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int unsigned NUM_ENTRIES = 256;
  localparam int unsigned ADDR_W      = $clog2(NUM_ENTRIES);

  // Flag bit positions inside an entry
  localparam int FB_PRESS   = 0;
  localparam int FB_RELEASE = 1;
  localparam int FB_HOLD    = 2;
  localparam int FB_TAP     = 3;
  localparam int FB_MULTI   = 4;
  localparam int FB_LONG    = 5;
  localparam int FB_WINDOW  = 6;
  localparam int FB_LTRIG   = 7;

  localparam logic [15:0] TAP_TIME_RST        = 16'd200;
  localparam logic [15:0] MULTI_TAP_TIME_RST  = 16'd300;
  localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd750;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_TICK    = 2'd2
  } bgc_mode_t;

  typedef enum logic [1:0] {
    CFG_TAP_TIME        = 2'd0,
    CFG_MULTI_TAP_TIME  = 2'd1,
    CFG_LONG_PRESS_TIME = 2'd2
  } bgc_cfg_idx_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  entry_index;
    logic [7:0]  repeat_in;
    logic [15:0] time_step_ms;
  } bgc_in_t;

  typedef struct packed {
    logic        pressed_now;
    logic        released_now;
    logic        held;
    logic [7:0]  repeat_now;
    logic        tap_flag;
    logic        multi_tap_flag;
    logic        long_press_flag;
    logic [7:0]  tap_total;
    logic [15:0] repeat_total;
  } bgc_out_t;

  typedef struct packed {
    logic [7:0]  flag_bits;
    logic [7:0]  repeat_latest;
    logic [15:0] held_time;
    logic [15:0] window_time;
    logic [7:0]  tap_counter;
    logic [15:0] repeat_counter;
  } bgc_entry_t;

  typedef struct packed {
    logic [15:0] tap_time_ms;
    logic [15:0] multi_tap_time_ms;
    logic [15:0] long_press_time_ms;
  } bgc_cfg_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic in_range(input logic [7:0] idx);
    return int'(idx) < int'(NUM_ENTRIES);
  endfunction

endpackage

// ===== rtl/bgc_store.sv =====
// ----------------------------------------------------------------------------
// bgc_store
// Entry table: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
module bgc_store
  import bgc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  bgc_entry_t        wr_data,
  output bgc_entry_t        rd_data
);

  bgc_entry_t             mem [NUM_ENTRIES];
  bgc_entry_t             rd_data_r;
  logic                   rd_vld_r;
  logic [NUM_ENTRIES-1:0] valid_r;
  logic                   bypass;

  assign bypass = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= bypass ? wr_data : mem[rd_addr];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= bypass || valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== rtl/bgc_update.sv =====
// ----------------------------------------------------------------------------
// bgc_update
// Gesture update of one entry: next entry value and the result item.
// ----------------------------------------------------------------------------
module bgc_update
  import bgc_pkg::*;
(
  input  bgc_in_t    item,
  input  bgc_entry_t cur,
  input  bgc_cfg_t   cfg,
  output logic       wr_en,
  output bgc_entry_t nxt,
  output bgc_out_t   result
);

  logic       ok;
  bgc_entry_t e;
  logic [7:0] f;

  always_comb begin
    ok    = in_range(item.entry_index);
    e     = cur;
    f     = cur.flag_bits;
    wr_en = 1'b0;
    case (item.mode)
      MODE_PRESS: begin
        wr_en = ok;
        if (!f[FB_HOLD]) begin
          f[FB_PRESS] = 1'b1;
        end
        f[FB_RELEASE]    = 1'b0;
        f[FB_HOLD]       = 1'b1;
        e.repeat_latest  = item.repeat_in;
        e.repeat_counter = sat_add16(e.repeat_counter, {8'd0, item.repeat_in});
        e.window_time    = '0;
      end
      MODE_RELEASE: begin
        wr_en            = ok;
        f[FB_PRESS]      = 1'b0;
        f[FB_HOLD]       = 1'b0;
        f[FB_LTRIG]      = 1'b0;
        f[FB_RELEASE]    = 1'b1;
        f[FB_WINDOW]     = 1'b1;
        e.repeat_latest  = '0;
        e.repeat_counter = '0;
        if (e.held_time < cfg.tap_time_ms) begin
          f[FB_TAP] = 1'b1;
        end
        e.held_time = '0;
      end
      MODE_TICK: begin
        wr_en           = ok;
        e.repeat_latest = '0;
        f[FB_TAP]       = 1'b0;
        f[FB_MULTI]     = 1'b0;
        f[FB_LONG]      = 1'b0;
        // multi-tap window aging
        if (f[FB_WINDOW]) begin
          e.window_time = sat_add16(e.window_time, item.time_step_ms);
          if (e.window_time > cfg.multi_tap_time_ms) begin
            e.window_time = '0;
            f[FB_WINDOW]  = 1'b0;
            e.tap_counter = '0;
          end
        end
        // press landed inside the window
        if (f[FB_PRESS] && f[FB_WINDOW]) begin
          if (e.window_time < cfg.multi_tap_time_ms) begin
            f[FB_MULTI] = 1'b1;
            if (e.tap_counter != 8'hFF) begin
              e.tap_counter = e.tap_counter + 8'd1;
            end
            e.window_time = '0;
          end
          f[FB_WINDOW] = 1'b0;
        end
        // hold aging, long press once per hold
        if (f[FB_HOLD]) begin
          f[FB_PRESS] = 1'b0;
          e.held_time = sat_add16(e.held_time, item.time_step_ms);
          if ((e.held_time > cfg.long_press_time_ms) && !f[FB_LTRIG]) begin
            f[FB_LTRIG] = 1'b1;
            f[FB_LONG]  = 1'b1;
            e.held_time = '0;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    e.flag_bits = f;
    nxt         = e;

    if (ok) begin
      result.pressed_now     = f[FB_PRESS];
      result.released_now    = f[FB_RELEASE];
      result.held            = f[FB_HOLD];
      result.repeat_now      = e.repeat_latest;
      result.tap_flag        = f[FB_TAP];
      result.multi_tap_flag  = f[FB_MULTI];
      result.long_press_flag = f[FB_LONG];
      result.tap_total       = e.tap_counter;
      result.repeat_total    = e.repeat_counter;
    end else begin
      result = '0;
    end
  end

endmodule

// ===== rtl/button_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Per-button tap, multi-tap and long-press detection over an entry table.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | in_data  (mode, entry, repeat, step)
//  out_    | out | out_valid/out_stall| out_data (flags and counters)
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_data (16 bit)
//
//  out_valid rises once the update retires: the table read is registered at
//  the accepting edge, and the update, write-back and result register take a
//  later edge, when the result register is free or draining. A request may be
//  accepted every cycle while the result register is free or being drained; a
//  same-entry follow-on request sees the fresh entry through the read bypass.
//  Reset is synchronous; per-entry valid bits clear the whole table at once,
//  so there is no clearing pass. When out_stall holds a full result register
//  and the update stage holds a request, that stage waits and in_stall rises.
// ----------------------------------------------------------------------------
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  bgc_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output bgc_out_t    out_data,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bgc_cfg_t   cfg_r;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  bgc_in_t    s1_item_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  bgc_out_t   out_data_r;

  logic       accept;
  logic       s1_go;
  bgc_entry_t rd_entry;
  bgc_entry_t wr_entry;
  logic       upd_wr;
  bgc_out_t   upd_result;

  // Config registers: to be written only while idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_time_ms        <= TAP_TIME_RST;
      cfg_r.multi_tap_time_ms  <= MULTI_TAP_TIME_RST;
      cfg_r.long_press_time_ms <= LONG_PRESS_TIME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TAP_TIME:        cfg_r.tap_time_ms        <= cfg_data;
        CFG_MULTI_TAP_TIME:  cfg_r.multi_tap_time_ms  <= cfg_data;
        CFG_LONG_PRESS_TIME: cfg_r.long_press_time_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Update stage advances when the result register is empty or draining.
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (s1_go) begin
      out_data_r <= upd_result;
    end
  end

  // Table read is issued at accept; write-back happens as the update retires.
  bgc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(in_data.entry_index)),
    .wr_en   (s1_go && upd_wr),
    .wr_addr (ADDR_W'(s1_item_r.entry_index)),
    .wr_data (wr_entry),
    .rd_data (rd_entry)
  );

  bgc_update u_update (
    .item   (s1_item_r),
    .cur    (rd_entry),
    .cfg    (cfg_r),
    .wr_en  (upd_wr),
    .nxt    (wr_entry),
    .result (upd_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bgc_checker.sv =====
// ----------------------------------------------------------------------------
// bgc_port_checker
// Port-level checks on the gesture classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_assert.svh"

module bgc_port_checker
  import bgc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input bgc_out_t out_data
);

  // a held result stays put
  `BGC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // input backs up only behind a full, stalled result register
  `BGC_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  // a press edge only shows on a held button
  `BGC_ASSERT_IMP(a_press_held, clk, rst_n, out_valid && out_data.pressed_now, out_data.held)
  // a released button is not held
  `BGC_ASSERT_IMP(a_rel_free, clk, rst_n, out_valid && out_data.released_now, !out_data.held)

endmodule

bind button_gesture_classifier bgc_port_checker u_bgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/bgc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_checker
// Watches the request, result and register ports of the gesture classifier,
// keeps its own copy of the entry table and thresholds, and compares every
// result against the flags predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module bgc_checker
  import bgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  bgc_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  bgc_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          results_checked
);

  bgc_entry_t  gesture_table [NUM_ENTRIES];
  logic [15:0] tap_limit;
  logic [15:0] window_limit;
  logic [15:0] long_limit;
  bgc_out_t    flags_due [$];

  function automatic logic [15:0] clamp16(input logic [15:0] a, input logic [15:0] b);
    return (32'(a) + 32'(b) > 32'd65535) ? 16'hFFFF : a + b;
  endfunction

  // Applies one request to the table copy and returns the entry's flags after it.
  function automatic bgc_out_t classify_request(input bgc_in_t req);
    bgc_entry_t  ent;
    logic [7:0]  f;
    bgc_out_t    res;
    if (int'(req.entry_index) >= int'(NUM_ENTRIES)) return '0;
    ent = gesture_table[req.entry_index];
    f   = ent.flag_bits;
    case (req.mode)
      MODE_PRESS: begin
        if (!f[FB_HOLD]) f[FB_PRESS] = 1'b1;
        f[FB_RELEASE]      = 1'b0;
        f[FB_HOLD]         = 1'b1;
        ent.repeat_latest  = req.repeat_in;
        ent.repeat_counter = clamp16(ent.repeat_counter, {8'd0, req.repeat_in});
        ent.window_time    = '0;
      end
      MODE_RELEASE: begin
        f[FB_PRESS]        = 1'b0;
        f[FB_HOLD]         = 1'b0;
        f[FB_LTRIG]        = 1'b0;
        f[FB_RELEASE]      = 1'b1;
        f[FB_WINDOW]       = 1'b1;
        ent.repeat_latest  = '0;
        ent.repeat_counter = '0;
        if (ent.held_time < tap_limit) f[FB_TAP] = 1'b1;
        ent.held_time      = '0;
      end
      MODE_TICK: begin
        ent.repeat_latest = '0;
        f[FB_TAP]   = 1'b0;
        f[FB_MULTI] = 1'b0;
        f[FB_LONG]  = 1'b0;
        // multi-tap window ages first and may expire
        if (f[FB_WINDOW]) begin
          ent.window_time = clamp16(ent.window_time, req.time_step_ms);
          if (ent.window_time > window_limit) begin
            ent.window_time = '0;
            f[FB_WINDOW]    = 1'b0;
            ent.tap_counter = '0;
          end
        end
        if (f[FB_PRESS] && f[FB_WINDOW]) begin
          if (ent.window_time < window_limit) begin
            f[FB_MULTI] = 1'b1;
            if (ent.tap_counter != 8'hFF) ent.tap_counter = ent.tap_counter + 8'd1;
            ent.window_time = '0;
          end
          f[FB_WINDOW] = 1'b0;
        end
        // long press fires once per hold
        if (f[FB_HOLD]) begin
          f[FB_PRESS]   = 1'b0;
          ent.held_time = clamp16(ent.held_time, req.time_step_ms);
          if (ent.held_time > long_limit && !f[FB_LTRIG]) begin
            f[FB_LTRIG]   = 1'b1;
            f[FB_LONG]    = 1'b1;
            ent.held_time = '0;
          end
        end
      end
      default: ;
    endcase
    ent.flag_bits = f;
    gesture_table[req.entry_index] = ent;
    res.pressed_now     = f[FB_PRESS];
    res.released_now    = f[FB_RELEASE];
    res.held            = f[FB_HOLD];
    res.repeat_now      = ent.repeat_latest;
    res.tap_flag        = f[FB_TAP];
    res.multi_tap_flag  = f[FB_MULTI];
    res.long_press_flag = f[FB_LONG];
    res.tap_total       = ent.tap_counter;
    res.repeat_total    = ent.repeat_counter;
    return res;
  endfunction

  task automatic report_fault(input string what);
    mismatches++;
    if (mismatches <= 25) $display("%0t bgc_checker: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_fault($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    bgc_out_t want;
    int       i;
    if (!rst_n) begin
      for (i = 0; i < NUM_ENTRIES; i++) gesture_table[i] = '0;
      tap_limit    = TAP_TIME_RST;
      window_limit = MULTI_TAP_TIME_RST;
      long_limit   = LONG_PRESS_TIME_RST;
      flags_due.delete();
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (flags_due.size() == 0) begin
          report_fault("result with no request outstanding");
        end else begin
          want = flags_due.pop_front();
          check_field("pressed_now", int'(out_data.pressed_now), int'(want.pressed_now));
          check_field("released_now", int'(out_data.released_now), int'(want.released_now));
          check_field("held", int'(out_data.held), int'(want.held));
          check_field("repeat_now", int'(out_data.repeat_now), int'(want.repeat_now));
          check_field("tap_flag", int'(out_data.tap_flag), int'(want.tap_flag));
          check_field("multi_tap_flag", int'(out_data.multi_tap_flag),
                      int'(want.multi_tap_flag));
          check_field("long_press_flag", int'(out_data.long_press_flag),
                      int'(want.long_press_flag));
          check_field("tap_total", int'(out_data.tap_total), int'(want.tap_total));
          check_field("repeat_total", int'(out_data.repeat_total), int'(want.repeat_total));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) flags_due.push_back(classify_request(in_data));
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TAP_TIME:        tap_limit    = cfg_data;
          CFG_MULTI_TAP_TIME:  window_limit = cfg_data;
          CFG_LONG_PRESS_TIME: long_limit   = cfg_data;
          default: ;
        endcase
      end
      pending = flags_due.size();
    end
  end

endmodule

// ===== test/tb_button_gesture_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_gesture_classifier
// Drives press, release and tick requests into the gesture classifier with
// bursty traffic and a randomly stalling result side. A directed opener hits
// field extremes and the unused mode, a long run saturates the repeat counter
// and a shorter one stacks multi-taps, then gesture-shaped random traffic runs
// under six threshold settings. The checker beside the block predicts and
// compares each result.
// ----------------------------------------------------------------------------
module tb_button_gesture_classifier
  import bgc_pkg::*;
();

  // Mode code the block must treat as a no-op read of the entry
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int HOLD_OFF_CYCLES = 80;  // long receiver hold-off
  localparam int SETTINGS_RUN    = 6;   // number of threshold settings
  localparam int RANDOM_QUOTA    = 90;  // minimum requests per setting
  localparam int TAP_RUNS        = 40;  // press/tick/release rounds in the tap run

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  bgc_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bgc_out_t    out_data;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  int          mismatches;
  int          pending;
  int          results_checked;

  int          requests_sent = 0;
  int          burst_left    = 0;    // requests left in the current sender burst
  logic        hold_off_req  = 1'b0; // asks the receiver for one long hold-off
  logic [7:0]  pool [4];             // entries the gesture traffic works on

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_gesture_classifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bgc_checker gesture_watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one request. Traffic comes in bursts: when a burst runs out, valid
  // drops for a random gap (sometimes none) before the next one starts. All
  // drives happen on the falling edge; acceptance is judged at the rising edge.
  task automatic issue(input logic [1:0] mode, input logic [7:0] entry,
                       input logic [7:0] rep, input logic [15:0] step);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid             = 1'b1;
    in_data.mode         = mode;
    in_data.entry_index  = entry;
    in_data.repeat_in    = rep;
    in_data.time_step_ms = step;
    // payload holds still while the block stalls us
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Drop valid and let every outstanding result drain. Each request yields a
  // result, so once nothing is pending the block is idle; a few spare cycles
  // cover the two-stage pipeline anyway.
  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input bgc_cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Tick steps spread around the default thresholds, with the odd huge step
  // and full saturation so timers clamp.
  function automatic logic [15:0] pick_step();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 8)  return 16'($urandom_range(0, 64));
    if (sel < 14) return 16'($urandom_range(0, 400));
    if (sel < 17) return 16'($urandom_range(0, 2000));
    if (sel < 19) return 16'($urandom_range(0, 65535));
    return 16'hFFFF;
  endfunction

  // Host frame tick on the entry, sometimes also sweeping a random pool entry.
  task automatic tick_entry(input logic [7:0] entry);
    issue(MODE_TICK, entry, 8'd0, pick_step());
    if ($urandom_range(0, 9) < 3)
      issue(MODE_TICK, pool[2'($urandom_range(0, 3))], 8'd0, pick_step());
  endtask

  // One well-formed gesture with random timing, or a couple of junk requests
  task automatic play_gesture();
    logic [7:0] e;
    int         kind;
    int         n;
    e    = pool[2'($urandom_range(0, 3))];
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      // single tap
      issue(MODE_PRESS, e, 8'd0, 16'd0);
      tick_entry(e);
      issue(MODE_RELEASE, e, 8'd0, 16'd0);
      tick_entry(e);
    end else if (kind < 5) begin
      // double tap: second press lands inside or outside the window
      repeat (2) begin
        issue(MODE_PRESS, e, 8'($urandom_range(0, 3)), 16'd0);
        tick_entry(e);
        issue(MODE_RELEASE, e, 8'd0, 16'd0);
        tick_entry(e);
      end
    end else if (kind < 7) begin
      // held key with auto-repeat presses, possibly crossing the long press
      issue(MODE_PRESS, e, 8'($urandom_range(0, 255)), 16'd0);
      n = $urandom_range(2, 5);
      repeat (n) begin
        tick_entry(e);
        if ($urandom_range(0, 1) == 1)
          issue(MODE_PRESS, e, 8'($urandom_range(1, 255)), 16'd0);
      end
      issue(MODE_RELEASE, e, 8'd0, 16'd0);
      tick_entry(e);
    end else if (kind == 7) begin
      // window left to run out
      issue(MODE_RELEASE, e, 8'd0, 16'd0);
      issue(MODE_TICK, e, 8'd0, 16'($urandom_range(0, 65535)));
    end else begin
      // noise: any mode including the unused one, any entry, any content
      repeat (2)
        issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: stalls on its own pattern, in stretches of random length.
  // Styles: free running, coin flip, light stall, and a steady pattern that stalls except at regular free slots.
  // When asked, it holds off for a long counted stretch so the block backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int style;
    int stretch;
    int k;
    forever begin
      style   = $urandom_range(0, 3);
      stretch = $urandom_range(8, 60);
      for (k = 0; k < stretch && !hold_off_req; k++) begin
        @(negedge clk);
        case (style)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 1) == 1);
          2: out_stall = ($urandom_range(0, 3) == 0);
          default: out_stall = (k % 4 != 0);
        endcase
      end
      if (hold_off_req) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall    = 1'b0;
        hold_off_req = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  e;
    logic [15:0] t_set;
    logic [15:0] m_set;
    logic [15:0] l_set;
    int          s;
    int          goal;
    logic        mid_done;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed opener on reset thresholds (tap 200, window 300, long 750).
    // Untouched entry first, then the unused mode.
    issue(MODE_TICK, 8'd0, 8'd0, 16'd0);
    issue(MODE_UNUSED, 8'd0, 8'hFF, 16'hFFFF);
    // press edge, then a repeat press while held (no new edge)
    issue(MODE_PRESS, 8'd0, 8'hFF, 16'd0);
    issue(MODE_PRESS, 8'd0, 8'd0, 16'd0);
    issue(MODE_TICK, 8'd0, 8'd0, 16'd100);
    // short hold -> tap, window opens
    issue(MODE_RELEASE, 8'd0, 8'd0, 16'd0);
    issue(MODE_TICK, 8'd0, 8'd0, 16'd50);
    // press inside the window -> multi-tap on the tick
    issue(MODE_PRESS, 8'd0, 8'd1, 16'd0);
    issue(MODE_TICK, 8'd0, 8'd0, 16'd10);
    // held time saturates: long press fires once, not twice
    issue(MODE_TICK, 8'd0, 8'd0, 16'hFFFF);
    issue(MODE_TICK, 8'd0, 8'd0, 16'hFFFF);
    issue(MODE_UNUSED, 8'd0, 8'd0, 16'd0);
    issue(MODE_RELEASE, 8'd0, 8'd0, 16'd0);
    // window saturates and expires, tap count clears
    issue(MODE_TICK, 8'd0, 8'd0, 16'hFFFF);
    // top entry, mixed bit patterns
    issue(MODE_PRESS, 8'hFF, 8'h80, 16'hAAAA);
    issue(MODE_TICK, 8'hFF, 8'h55, 16'hFFFF);
    issue(MODE_RELEASE, 8'hFF, 8'hAA, 16'h5555);
    issue(MODE_TICK, 8'hFF, 8'd0, 16'd1);
    issue(MODE_PRESS, 8'hFF, 8'h7F, 16'd0);
    issue(MODE_TICK, 8'hFF, 8'd0, 16'd0);
    issue(MODE_RELEASE, 8'hA5, 8'h5A, 16'h0F0F);
    issue(MODE_TICK, 8'hA5, 8'd0, 16'h3000);

    // Repeat total saturation: full-count auto-repeats on one held key
    e = 8'($urandom_range(1, 254));
    repeat (258) issue(MODE_PRESS, e, 8'hFF, 16'd0);
    issue(MODE_RELEASE, e, 8'd0, 16'd0);

    // Tap total build-up: keep re-pressing inside the window
    e = 8'($urandom_range(1, 254));
    issue(MODE_PRESS, e, 8'd0, 16'd0);
    issue(MODE_RELEASE, e, 8'd0, 16'd0);
    repeat (TAP_RUNS) begin
      issue(MODE_PRESS, e, 8'd0, 16'd0);
      issue(MODE_TICK, e, 8'd0, 16'($urandom_range(0, 150)));
      issue(MODE_RELEASE, e, 8'd0, 16'd0);
    end

    // Random gesture traffic under a series of threshold settings,
    // extremes included; registers only change with the block drained.
    for (s = 0; s < SETTINGS_RUN; s++) begin
      case (s)
        0: begin
          t_set = 16'd0;      m_set = 16'd0;      l_set = 16'd0;
        end
        1: begin
          t_set = 16'hFFFF;   m_set = 16'hFFFF;   l_set = 16'hFFFF;
        end
        2: begin
          t_set = TAP_TIME_RST; m_set = MULTI_TAP_TIME_RST; l_set = LONG_PRESS_TIME_RST;
        end
        3: begin
          t_set = 16'($urandom_range(0, 1000));
          m_set = 16'($urandom_range(0, 1000));
          l_set = 16'($urandom_range(0, 1000));
        end
        4: begin
          t_set = 16'($urandom_range(50, 400));
          m_set = 16'($urandom_range(100, 600));
          l_set = 16'($urandom_range(200, 1500));
        end
        default: begin
          t_set = 16'd1;      m_set = 16'hFFFF;   l_set = 16'd0;
        end
      endcase
      drain_block();
      write_reg(CFG_TAP_TIME, t_set);
      write_reg(CFG_MULTI_TAP_TIME, m_set);
      write_reg(CFG_LONG_PRESS_TIME, l_set);

      // small working set, now and then pinned to the table ends
      foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) pool[0] = 8'd0;
      if ($urandom_range(0, 1) == 1) pool[3] = 8'hFF;

      goal     = requests_sent + RANDOM_QUOTA;
      mid_done = 1'b0;
      while (requests_sent < goal) begin
        // midway through one setting the receiver holds off while we keep
        // offering back to back; in another the sender waits for a full drain
        if (!mid_done && requests_sent >= goal - RANDOM_QUOTA / 2) begin
          mid_done = 1'b1;
          if (s == 3) begin
            hold_off_req = 1'b1;
            burst_left   = 40;
          end
          if (s == 4) drain_block();
        end
        play_gesture();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests (%0d results checked): field extremes, unused mode,",
             requests_sent, results_checked);
    $display("repeat saturation, stacked taps and %0d threshold settings under bursty traffic.",
             SETTINGS_RUN);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
